[design/eps_pkg.sv]
// Package for the entropy patch segmenter: beat types, register codes and constants.
`timescale 1ns / 1ps

package eps_pkg;

   localparam int MAX_SEQUENCE_DEFAULT = 65536;
   localparam int RSP_DEPTH            = 4;

   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

   // Configuration register indexes.
   localparam logic [2:0] CSR_NEWLINE_RESET    = 3'd0;
   localparam logic [2:0] CSR_MAX_LENGTH       = 3'd1;
   localparam logic [2:0] CSR_BOUNDARY_RULE    = 3'd2;
   localparam logic [2:0] CSR_GLOBAL_THRESHOLD = 3'd3;
   localparam logic [2:0] CSR_RISE_THRESHOLD   = 3'd4;
   localparam logic [2:0] CSR_PATCH_CAP        = 3'd5;

   // Boundary rule codes.
   localparam logic [1:0] RULE_GLOBAL = 2'd0;
   localparam logic [1:0] RULE_RISE   = 2'd1;
   localparam logic [1:0] RULE_EITHER = 2'd2;
   localparam logic [1:0] RULE_NONE   = 2'd3;

   // Register reset values.
   localparam logic [15:0] MAX_LENGTH_RESET = 16'd16;
   localparam logic [15:0] PATCH_CAP_RESET  = 16'hFFFF;

   typedef struct packed {
      logic               newline_reset;
      logic [15:0]        max_length;
      logic [1:0]         boundary_rule;
      logic [15:0]        global_threshold;
      logic signed [16:0] rise_threshold;
      logic [15:0]        patch_cap;
   } eps_cfg_type;

   typedef struct packed {
      logic [7:0]  byte_value;
      logic [15:0] entropy;
      logic        end_of_input;
   } eps_req_type;

   typedef struct packed {
      logic [15:0] first_index;
      logic [16:0] patch_length;
      logic [15:0] patch_peak;
      logic [15:0] patch_number;
      logic        patch_valid;
      logic        sequence_done;
      logic        truncated;
   } eps_rsp_type;

endpackage

[design/eps_decide.sv]
// Boundary decision and next-state logic for one accepted byte.
`timescale 1ns / 1ps

module eps_decide
   import eps_pkg::*;
#(
   parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEFAULT
) (
   input  eps_cfg_type                       cfg,
   input  eps_req_type                       item,
   input  logic [$clog2(MAX_SEQUENCE)-1:0]   position_ff,
   input  logic [$clog2(MAX_SEQUENCE)-1:0]   open_start_ff,
   input  logic [$clog2(MAX_SEQUENCE):0]     open_length_ff,
   input  logic [15:0]                       open_peak_ff,
   input  logic [15:0]                       prev_entropy_ff,
   input  logic [15:0]                       emitted_ff,
   input  logic                              cap_reached_ff,
   input  logic                              in_sequence_ff,
   output logic [$clog2(MAX_SEQUENCE)-1:0]   position_in,
   output logic [$clog2(MAX_SEQUENCE)-1:0]   open_start_in,
   output logic [$clog2(MAX_SEQUENCE):0]     open_length_in,
   output logic [15:0]                       open_peak_in,
   output logic [15:0]                       prev_entropy_in,
   output logic [15:0]                       emitted_in,
   output logic                              cap_reached_in,
   output logic                              in_sequence_in,
   output logic [1:0]                        push_count,
   output eps_rsp_type                       push_a,
   output eps_rsp_type                       push_b
);

   localparam int POS_W = $clog2(MAX_SEQUENCE);
   localparam int LEN_W = POS_W + 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_SEQUENCE - 1);
   localparam logic [POS_W:0]   POS_LAST_WIDE = (POS_W + 1)'(MAX_SEQUENCE - 1);

   function automatic eps_rsp_type make_result(
      input logic [POS_W-1:0] start,
      input logic [LEN_W-1:0] len,
      input logic [15:0]      peak,
      input logic [15:0]      num,
      input logic             valid,
      input logic             done,
      input logic             trunc
   );
      eps_rsp_type r;
      logic [31:0] start32;
      logic [31:0] len32;
      start32         = 32'(start);
      len32           = 32'(len);
      r.first_index   = start32[15:0];
      r.patch_length  = (len32 > 32'h1FFFF) ? 17'h1FFFF : len32[16:0];
      r.patch_peak    = peak;
      r.patch_number  = num;
      r.patch_valid   = valid;
      r.sequence_done = done;
      r.truncated     = trunc;
      return r;
   endfunction

   logic [POS_W:0]     idx_wide;
   logic [POS_W-1:0]   idx;
   logic               last;
   logic               glob_hit;
   logic               rise_hit;
   logic               rule_hit;
   logic               boundary;
   logic signed [17:0] rise;
   logic               finish;
   logic               res0_valid;
   logic               res1_valid;
   eps_rsp_type        res0;
   eps_rsp_type        res1;

   always_comb begin
      idx_wide = {1'b0, position_ff} + (POS_W + 1)'(1);
      if (idx_wide >= POS_LAST_WIDE) begin
         idx  = POS_LAST;
         last = 1'b1;
      end else begin
         idx  = idx_wide[POS_W-1:0];
         last = item.end_of_input;
      end
   end

   always_comb begin
      glob_hit = item.entropy > cfg.global_threshold;
      rise     = $signed({2'b00, item.entropy}) - $signed({2'b00, prev_entropy_ff});
      rise_hit = rise > 18'(cfg.rise_threshold);
      unique case (cfg.boundary_rule)
         RULE_GLOBAL: rule_hit = glob_hit;
         RULE_RISE:   rule_hit = rise_hit;
         RULE_EITHER: rule_hit = glob_hit || rise_hit;
         RULE_NONE:   rule_hit = 1'b0;
      endcase
      boundary = (cfg.newline_reset && (item.byte_value == NEWLINE_BYTE))
               || (32'(open_length_ff) >= 32'(cfg.max_length))
               || rule_hit;
   end

   always_comb begin
      position_in     = position_ff;
      open_start_in   = open_start_ff;
      open_length_in  = open_length_ff;
      open_peak_in    = open_peak_ff;
      prev_entropy_in = prev_entropy_ff;
      emitted_in      = emitted_ff;
      cap_reached_in  = cap_reached_ff;
      in_sequence_in  = in_sequence_ff;
      res0_valid      = 1'b0;
      res1_valid      = 1'b0;
      res0            = '0;
      res1            = '0;
      finish          = 1'b0;

      if (!in_sequence_ff) begin
         // The first byte opens a patch at index zero and clears the count.
         position_in     = '0;
         open_start_in   = '0;
         open_length_in  = LEN_W'(1);
         open_peak_in    = item.entropy;
         prev_entropy_in = item.entropy;
         emitted_in      = '0;
         cap_reached_in  = 1'b0;
         in_sequence_in  = 1'b1;
         finish          = item.end_of_input;
      end else begin
         position_in = idx;
         finish      = last;
         if (!cap_reached_ff) begin
            if (boundary) begin
               if (emitted_ff >= cfg.patch_cap) begin
                  cap_reached_in = 1'b1;
               end else begin
                  emitted_in     = emitted_ff + 16'd1;
                  res0_valid     = 1'b1;
                  res0           = make_result(open_start_ff, open_length_ff, open_peak_ff,
                                               emitted_in, 1'b1, 1'b0, 1'b0);
                  open_start_in  = idx;
                  open_length_in = LEN_W'(1);
                  open_peak_in   = item.entropy;
               end
            end else begin
               open_length_in = open_length_ff + LEN_W'(1);
               if (item.entropy > open_peak_ff) begin
                  open_peak_in = item.entropy;
               end
            end
            prev_entropy_in = item.entropy;
         end
      end

      if (finish) begin
         in_sequence_in = 1'b0;
         res1_valid     = 1'b1;
         if (!cap_reached_in && (emitted_in < cfg.patch_cap)) begin
            emitted_in = emitted_in + 16'd1;
            res1       = make_result(open_start_in, open_length_in, open_peak_in,
                                     emitted_in, 1'b1, 1'b1, 1'b0);
         end else begin
            // Truncated end marker: no patch, only the count so far.
            cap_reached_in = 1'b1;
            res1           = make_result('0, '0, 16'd0, emitted_in, 1'b0, 1'b1, 1'b1);
         end
      end
   end

   assign push_count = {1'b0, res0_valid} + {1'b0, res1_valid};
   assign push_a     = res0_valid ? res0 : res1;
   assign push_b     = res1;

endmodule

[design/eps_rsp_queue.sv]
// Result queue that takes up to two beats per cycle and hands out one.
`timescale 1ns / 1ps

module eps_rsp_queue
   import eps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  push_count,
   input  eps_rsp_type push_a,
   input  eps_rsp_type push_b,
   input  logic        pop,
   output logic        head_valid,
   output eps_rsp_type head,
   output logic        no_room,
   output logic [$clog2(RSP_DEPTH):0] count
);

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   eps_rsp_type      entry_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_a;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push_b;
      end
   end

   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];
   // Keep room for the two beats that one byte can cause.
   assign no_room    = count_ff > CNT_W'(RSP_DEPTH - 2);
   assign count      = count_ff;

endmodule

[design/entropy_patch_segmenter_core.sv]
// Top level of the entropy patch segmenter: registers, running state and result queue.
// A patch closed by an accepted byte is written into the result queue and offered on rsp from there.
// Throughput: one byte per cycle while req_stall is low; a byte that closes a patch and ends the sequence
// gives two result beats, and req_stall rises while the four-entry result queue
// lacks room for two beats.
// Reset: synchronous, active high; registers take their reset values and the queue empties.
`timescale 1ns / 1ps

module entropy_patch_segmenter_core
   import eps_pkg::*;
#(
   parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  eps_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output eps_rsp_type rsp_payload,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data
);

   localparam int POS_W = $clog2(MAX_SEQUENCE);
   localparam int LEN_W = POS_W + 1;

   eps_cfg_type      cfg_ff;
   logic [POS_W-1:0] position_ff;
   logic [POS_W-1:0] open_start_ff;
   logic [LEN_W-1:0] open_length_ff;
   logic [15:0]      open_peak_ff;
   logic [15:0]      prev_entropy_ff;
   logic [15:0]      emitted_ff;
   logic             cap_reached_ff;
   logic             in_sequence_ff;

   logic [POS_W-1:0] position_in;
   logic [POS_W-1:0] open_start_in;
   logic [LEN_W-1:0] open_length_in;
   logic [15:0]      open_peak_in;
   logic [15:0]      prev_entropy_in;
   logic [15:0]      emitted_in;
   logic             cap_reached_in;
   logic             in_sequence_in;

   logic             req_accept;
   logic             rsp_accept;
   logic [1:0]       push_count;
   eps_rsp_type      push_a;
   eps_rsp_type      push_b;
   logic             no_room;
   logic [$clog2(RSP_DEPTH):0] queue_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.newline_reset    <= 1'b0;
         cfg_ff.max_length       <= MAX_LENGTH_RESET;
         cfg_ff.boundary_rule    <= RULE_GLOBAL;
         cfg_ff.global_threshold <= '0;
         cfg_ff.rise_threshold   <= '0;
         cfg_ff.patch_cap        <= PATCH_CAP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_NEWLINE_RESET:    cfg_ff.newline_reset    <= csr_data[0];
            CSR_MAX_LENGTH:       cfg_ff.max_length       <= csr_data[15:0];
            CSR_BOUNDARY_RULE:    cfg_ff.boundary_rule    <= csr_data[1:0];
            CSR_GLOBAL_THRESHOLD: cfg_ff.global_threshold <= csr_data[15:0];
            CSR_RISE_THRESHOLD:   cfg_ff.rise_threshold   <= $signed(csr_data);
            CSR_PATCH_CAP:        cfg_ff.patch_cap        <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign req_stall  = no_room;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   eps_decide #(
      .MAX_SEQUENCE(MAX_SEQUENCE)
   ) u_decide (
      .cfg            (cfg_ff),
      .item           (req_payload),
      .position_ff    (position_ff),
      .open_start_ff  (open_start_ff),
      .open_length_ff (open_length_ff),
      .open_peak_ff   (open_peak_ff),
      .prev_entropy_ff(prev_entropy_ff),
      .emitted_ff     (emitted_ff),
      .cap_reached_ff (cap_reached_ff),
      .in_sequence_ff (in_sequence_ff),
      .position_in    (position_in),
      .open_start_in  (open_start_in),
      .open_length_in (open_length_in),
      .open_peak_in   (open_peak_in),
      .prev_entropy_in(prev_entropy_in),
      .emitted_in     (emitted_in),
      .cap_reached_in (cap_reached_in),
      .in_sequence_in (in_sequence_in),
      .push_count     (push_count),
      .push_a         (push_a),
      .push_b         (push_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff     <= '0;
         open_start_ff   <= '0;
         open_length_ff  <= '0;
         open_peak_ff    <= '0;
         prev_entropy_ff <= '0;
         emitted_ff      <= '0;
         cap_reached_ff  <= 1'b0;
         in_sequence_ff  <= 1'b0;
      end else if (req_accept) begin
         position_ff     <= position_in;
         open_start_ff   <= open_start_in;
         open_length_ff  <= open_length_in;
         open_peak_ff    <= open_peak_in;
         prev_entropy_ff <= prev_entropy_in;
         emitted_ff      <= emitted_in;
         cap_reached_ff  <= cap_reached_in;
         in_sequence_ff  <= in_sequence_in;
      end
   end

   eps_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_count(req_accept ? push_count : 2'd0),
      .push_a    (push_a),
      .push_b    (push_b),
      .pop       (rsp_accept),
      .head_valid(rsp_valid),
      .head      (rsp_payload),
      .no_room   (no_room),
      .count     (queue_count)
   );

`ifndef SYNTHESIS
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      queue_count <= ($clog2(RSP_DEPTH) + 1)'(RSP_DEPTH))
      else $error("result queue count exceeds its depth");

   a_end_closes : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_payload.end_of_input) |=> !in_sequence_ff)
      else $error("sequence still open after its last byte");

   a_marker_form : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.patch_valid) |->
         (rsp_payload.sequence_done && rsp_payload.truncated))
      else $error("beat without a patch is not a truncated end marker");

   a_done_clears : assert property (@(posedge clock) disable iff (reset)
      (req_accept && push_count == 2'd0) |-> !(!in_sequence_ff && req_payload.end_of_input))
      else $error("single-byte sequence produced no beat");
`endif

endmodule

[tb/tb_entropy_patch_segmenter_core.sv]
// Self-checking testbench for the entropy patch segmenter core.
`timescale 1ns / 1ps

module tb_entropy_patch_segmenter_core;
   import eps_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_LENGTH    = 300;
   localparam int TAIL_CYCLES    = 20;
   localparam int SEQ_LIMIT      = MAX_SEQUENCE_DEFAULT;

   // Indexes past the six registers; writes to them are ignored.
   localparam logic [2:0] CSR_UNUSED_A = 3'd6;
   localparam logic [2:0] CSR_UNUSED_B = 3'd7;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   eps_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   eps_rsp_type rsp_payload;
   logic        csr_write   = 1'b0;
   logic [2:0]  csr_index   = '0;
   logic [16:0] csr_data    = '0;

   eps_req_type pending_bytes[$];
   eps_rsp_type expected_patches[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   bit hold_armed         = 1'b0;
   int hold_cycles        = 0;
   int idle_cycles        = 0;
   int error_count        = 0;
   int entropy_focus      = 0;

   // Predicted register file and running segmentation state.
   eps_cfg_type cfg_model;
   logic [15:0] seg_position;
   logic [15:0] seg_start;
   logic [16:0] seg_length;
   logic [15:0] seg_peak;
   logic [15:0] seg_prev_entropy;
   logic [15:0] seg_emitted;
   bit          seg_cap_hit;
   bit          seg_active;

   entropy_patch_segmenter_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   function automatic bit emit_patch(input bit done);
      eps_rsp_type patch;
      if (seg_emitted >= cfg_model.patch_cap) begin
         seg_cap_hit = 1'b1;
         return 1'b0;
      end
      seg_emitted          = seg_emitted + 16'd1;
      patch.first_index    = seg_start;
      patch.patch_length   = seg_length;
      patch.patch_peak     = seg_peak;
      patch.patch_number   = seg_emitted;
      patch.patch_valid    = 1'b1;
      patch.sequence_done  = done;
      patch.truncated      = 1'b0;
      expected_patches.push_back(patch);
      return 1'b1;
   endfunction

   function automatic void close_sequence();
      eps_rsp_type marker;
      seg_active = 1'b0;
      if (!seg_cap_hit && emit_patch(1'b1))
         return;
      // The cap cut the sequence off, so only a truncation marker is given.
      marker               = '0;
      marker.patch_number  = seg_emitted;
      marker.sequence_done = 1'b1;
      marker.truncated     = 1'b1;
      expected_patches.push_back(marker);
   endfunction

   function automatic void segment_byte(input eps_req_type beat);
      int idx;
      bit last;
      bit boundary;
      bit over_global;
      bit over_rise;
      last = beat.end_of_input;
      if (!seg_active) begin
         seg_active       = 1'b1;
         seg_position     = '0;
         seg_start        = '0;
         seg_length       = 17'd1;
         seg_peak         = beat.entropy;
         seg_prev_entropy = beat.entropy;
         seg_emitted      = '0;
         seg_cap_hit      = 1'b0;
         if (last)
            close_sequence();
         return;
      end
      idx = int'(seg_position) + 1;
      // A sequence that runs too long is closed at its last legal index.
      if (idx >= SEQ_LIMIT - 1) begin
         idx  = SEQ_LIMIT - 1;
         last = 1'b1;
      end
      seg_position = idx[15:0];
      if (!seg_cap_hit) begin
         over_global = beat.entropy > cfg_model.global_threshold;
         over_rise   = (int'(beat.entropy) - int'(seg_prev_entropy)) >
                       int'($signed(cfg_model.rise_threshold));
         case (cfg_model.boundary_rule)
            RULE_GLOBAL: boundary = over_global;
            RULE_RISE:   boundary = over_rise;
            RULE_EITHER: boundary = over_global || over_rise;
            default:     boundary = 1'b0;
         endcase
         if (cfg_model.newline_reset && beat.byte_value == NEWLINE_BYTE)
            boundary = 1'b1;
         if (seg_length >= cfg_model.max_length)
            boundary = 1'b1;
         if (boundary) begin
            if (emit_patch(1'b0)) begin
               seg_start  = idx[15:0];
               seg_length = 17'd1;
               seg_peak   = beat.entropy;
            end
         end else begin
            seg_length = seg_length + 17'd1;
            if (beat.entropy > seg_peak)
               seg_peak = beat.entropy;
         end
         seg_prev_entropy = beat.entropy;
      end
      if (last)
         close_sequence();
   endfunction

   // Driver: feeds byte beats and tracks the register file as the block sees it.
   always @(posedge clock) begin
      if (reset) begin
         req_valid                  <= 1'b0;
         cfg_model.newline_reset    = 1'b0;
         cfg_model.max_length       = MAX_LENGTH_RESET;
         cfg_model.boundary_rule    = RULE_GLOBAL;
         cfg_model.global_threshold = '0;
         cfg_model.rise_threshold   = '0;
         cfg_model.patch_cap        = PATCH_CAP_RESET;
         seg_position               = '0;
         seg_start                  = '0;
         seg_length                 = '0;
         seg_peak                   = '0;
         seg_prev_entropy           = '0;
         seg_emitted                = '0;
         seg_cap_hit                = 1'b0;
         seg_active                 = 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_NEWLINE_RESET:    cfg_model.newline_reset    = csr_data[0];
               CSR_MAX_LENGTH:       cfg_model.max_length       = csr_data[15:0];
               CSR_BOUNDARY_RULE:    cfg_model.boundary_rule    = csr_data[1:0];
               CSR_GLOBAL_THRESHOLD: cfg_model.global_threshold = csr_data[15:0];
               CSR_RISE_THRESHOLD:   cfg_model.rise_threshold   = csr_data;
               CSR_PATCH_CAP:        cfg_model.patch_cap        = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            segment_byte(req_payload);
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off that lets the block back up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_armed && hold_cycles < HOLD_LENGTH) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : result_monitor
      eps_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_patches.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat start=%0d length=%0d",
                                      rsp_payload.first_index, rsp_payload.patch_length));
         end else begin
            want = expected_patches.pop_front();
            check_field("first_index", rsp_payload.first_index, want.first_index);
            check_field("patch_length", rsp_payload.patch_length, want.patch_length);
            check_field("patch_peak", rsp_payload.patch_peak, want.patch_peak);
            check_field("patch_number", rsp_payload.patch_number, want.patch_number);
            check_field("patch_valid", rsp_payload.patch_valid, want.patch_valid);
            check_field("sequence_done", rsp_payload.sequence_done, want.sequence_done);
            check_field("truncated", rsp_payload.truncated, want.truncated);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding", expected_patches.size());
         $display("[entropy_patch_segmenter_core] ERROR");
         $finish;
      end
   end

   function automatic void push_byte(input logic [7:0] value, input logic [15:0] ent,
                                     input bit last);
      eps_req_type beat;
      beat.byte_value   = value;
      beat.entropy      = ent;
      beat.end_of_input = last;
      pending_bytes.push_back(beat);
   endfunction

   // Entropy values cluster around the threshold and the previous byte so
   // that both rules fire often, with the range extremes mixed in.
   function automatic int shape_entropy(input int prev);
      int e;
      case ($urandom_range(4))
         0:       e = int'($urandom_range(0, 65535));
         1:       e = int'($urandom_range(0, 4095));
         2:       e = entropy_focus + int'($urandom_range(0, 64)) - 32;
         3:       e = prev + int'($urandom_range(0, 4096)) - 2048;
         default: e = ($urandom_range(1) != 0) ? 65535 : 0;
      endcase
      if (e < 0)
         e = 0;
      if (e > 65535)
         e = 65535;
      return e;
   endfunction

   function automatic void queue_sequence(input int len);
      int e;
      logic [7:0] value;
      e = int'($urandom_range(0, 65535));
      for (int i = 0; i < len; i++) begin
         e     = shape_entropy(e);
         value = ($urandom_range(5) == 0) ? NEWLINE_BYTE : 8'($urandom_range(255));
         push_byte(value, 16'(e), i == len - 1);
      end
   endfunction

   task automatic write_csr(input logic [2:0] index, input logic [16:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
   endtask

   task automatic configure(input bit nl, input logic [15:0] maxl, input logic [1:0] rule,
                            input logic [15:0] gthr, input logic [16:0] rise,
                            input logic [15:0] cap);
      write_csr(CSR_NEWLINE_RESET, 17'(nl));
      write_csr(CSR_MAX_LENGTH, 17'(maxl));
      write_csr(CSR_BOUNDARY_RULE, 17'(rule));
      write_csr(CSR_GLOBAL_THRESHOLD, 17'(gthr));
      write_csr(CSR_RISE_THRESHOLD, rise);
      write_csr(CSR_PATCH_CAP, 17'(cap));
      csr_write <= 1'b0;
   endtask

   // Waits until every byte is in and every predicted result has come out.
   task automatic settle();
      while (pending_bytes.size() != 0 || req_valid || expected_patches.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      int          generated;
      int          len;
      bit          nl;
      logic [15:0] maxl;
      logic [1:0]  rule;
      logic [15:0] gthr;
      logic [16:0] rise;
      logic [15:0] cap;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: a one-byte sequence, then a last byte that both
      // closes a patch and ends the sequence.
      push_byte(8'h00, 16'h0000, 1'b1);
      push_byte(8'hFF, 16'h0000, 1'b0);
      push_byte(8'h0A, 16'h0000, 1'b0);
      push_byte(8'h55, 16'hFFFF, 1'b0);
      push_byte(8'h0A, 16'h0001, 1'b1);
      settle();

      configure(1'b1, 16'hFFFF, RULE_NONE, 16'h0000, 17'h00000, 16'hFFFF);
      push_byte(8'h41, 16'h1000, 1'b0);
      push_byte(8'h0A, 16'h1000, 1'b0);
      push_byte(8'h0A, 16'h2000, 1'b0);
      push_byte(8'h42, 16'h0000, 1'b1);
      settle();

      // Zero maximum length: every byte after the first opens a patch.
      configure(1'b0, 16'h0000, RULE_NONE, 16'hFFFF, 17'h00000, 16'hFFFF);
      push_byte(8'h10, 16'h0123, 1'b0);
      push_byte(8'h20, 16'h4567, 1'b0);
      push_byte(8'h30, 16'h89AB, 1'b1);
      settle();

      // A rise threshold of minus one fires on any byte that does not fall.
      configure(1'b0, 16'hFFFF, RULE_RISE, 16'h0000, 17'h1FFFF, 16'hFFFF);
      push_byte(8'h01, 16'd100, 1'b0);
      push_byte(8'h02, 16'd100, 1'b0);
      push_byte(8'h03, 16'd50, 1'b0);
      push_byte(8'h04, 16'hFFFF, 1'b1);
      settle();

      // A zero cap leaves only the truncation marker.
      configure(1'b0, 16'hFFFF, RULE_EITHER, 16'h8000, 17'h0FFFF, 16'h0000);
      push_byte(8'hAA, 16'hFFFF, 1'b0);
      push_byte(8'h0A, 16'h0000, 1'b1);
      settle();

      // A cap of one is hit at the second boundary; later bytes are ignored.
      write_csr(CSR_UNUSED_A, 17'($urandom));
      write_csr(CSR_UNUSED_B, 17'($urandom));
      configure(1'b0, 16'h0001, RULE_GLOBAL, 16'hFFFF, 17'h10000, 16'h0001);
      push_byte(8'h11, 16'h0000, 1'b0);
      push_byte(8'h22, 16'hFFFF, 1'b0);
      push_byte(8'h33, 16'h7777, 1'b0);
      push_byte(8'h44, 16'h0001, 1'b1);
      settle();

      for (int phase = 0; phase < 8; phase++) begin
         nl   = 1'($urandom_range(1));
         rule = 2'($urandom_range(3));
         case ($urandom_range(4))
            0:       maxl = 16'h0000;
            1:       maxl = 16'h0001;
            4:       maxl = 16'hFFFF;
            default: maxl = 16'($urandom_range(2, 24));
         endcase
         case ($urandom_range(3))
            0:       gthr = 16'h0000;
            1:       gthr = 16'hFFFF;
            default: gthr = 16'($urandom_range(0, 65535));
         endcase
         case ($urandom_range(5))
            0:       rise = 17'h10001;
            1:       rise = 17'h0FFFF;
            2:       rise = 17'h10000;
            3:       rise = 17'($urandom);
            default: rise = 17'(int'($urandom_range(0, 4096)) - 2048);
         endcase
         case ($urandom_range(4))
            0:       cap = 16'h0000;
            1:       cap = 16'h0001;
            2:       cap = 16'($urandom_range(2, 8));
            default: cap = 16'hFFFF;
         endcase
         configure(nl, maxl, rule, gthr, rise, cap);
         entropy_focus = int'(gthr);
         case (phase % 4)
            0: begin sender_idle_pct <= 0;  receiver_stall_pct <= 0;  end
            1: begin sender_idle_pct <= 65; receiver_stall_pct <= 0;  end
            2: begin sender_idle_pct <= 0;  receiver_stall_pct <= 65; end
            default: begin sender_idle_pct <= 31; receiver_stall_pct <= 31; end
         endcase
         if (phase == 4)
            hold_armed <= 1'b1;
         generated = 0;
         while (generated < 125) begin
            if ($urandom_range(9) == 0) begin
               // Noise beat with a random end flag.
               push_byte(8'($urandom_range(255)), 16'($urandom_range(0, 65535)),
                         $urandom_range(3) == 0);
               generated++;
            end else begin
               len = ($urandom_range(7) == 0) ? int'($urandom_range(30, 80))
                                              : int'($urandom_range(1, 30));
               queue_sequence(len);
               generated += len;
            end
         end
         settle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_patches.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_patches.size()));
      if (error_count == 0)
         $display("[entropy_patch_segmenter_core] OK");
      else
         $display("[entropy_patch_segmenter_core] ERROR");
      $finish;
   end

endmodule

[filelist.f]
design/eps_pkg.sv
design/eps_decide.sv
design/eps_rsp_queue.sv
design/entropy_patch_segmenter_core.sv
tb/tb_entropy_patch_segmenter_core.sv
